// ----- rtl/core/urm_pkg.sv -----
package urm_pkg;

  typedef struct packed {
    logic [1:0] command;
    logic       echo_level;
    logic       unit_select;
    logic [7:0] sample_count;
  } in_beat_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic        invalid;
    logic [15:0] distance;
  } out_beat_t;

  localparam logic [1:0] CMD_SINGLE = 2'd1;
  localparam logic [1:0] CMD_MEDIAN = 2'd2;

  localparam logic [2:0] REG_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_TRIGLEN = 3'd1;
  localparam logic [2:0] REG_CM      = 3'd2;
  localparam logic [2:0] REG_INCH    = 3'd3;
  localparam logic [2:0] REG_GAP     = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic start;     // latch tick and run the phase logic
    logic div_step;  // one restoring division bit
    logic ins_step;  // one insertion shift step
    logic finish;    // build the result beat
  } urm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic need_div;  // sample ended with a width to convert
    logic need_ins;  // converted value goes to the sorted store
    logic div_last;
    logic ins_last;
  } urm_sts_t;

endpackage

// ----- rtl/core/urm_ctrl.sv -----
module urm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output urm_pkg::urm_cmd_t cmd,
  input  urm_pkg::urm_sts_t sts
);
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.start    = in_ready && in_valid;
    cmd.div_step = (state_r == S_DIV);
    cmd.ins_step = (state_r == S_INS);
    cmd.finish   = (state_r == S_FIN);
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EVAL;
      S_EVAL: state_nxt = sts.need_div ? S_DIV : S_FIN;
      S_DIV:  if (sts.div_last) state_nxt = sts.need_ins ? S_INS : S_FIN;
      S_INS:  if (sts.ins_last) state_nxt = S_FIN;
      S_FIN:  state_nxt = S_OUT;
      S_OUT:  if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end
endmodule

// ----- rtl/core/urm_datapath.sv -----
module urm_datapath #(
  parameter int MAX_SAMPLES = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  urm_pkg::in_beat_t  in_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata,
  input  urm_pkg::urm_cmd_t  cmd,
  output urm_pkg::urm_sts_t  sts,
  output urm_pkg::out_beat_t out_data
);
  localparam int CW = $clog2(MAX_SAMPLES + 1);
  localparam int IW = $clog2(MAX_SAMPLES);
  localparam int TOP = (MAX_SAMPLES % 2 == 1) ? MAX_SAMPLES : MAX_SAMPLES - 1;
  localparam logic [2:0] PH_IDLE = 3'd0, PH_TLOW = 3'd1, PH_THIGH = 3'd2,
                         PH_WAIT = 3'd3, PH_MEAS = 3'd4, PH_GAP = 3'd5;

  logic [23:0] timeout_r;
  logic [7:0]  trig_len_r, per_cm_r, per_inch_r;
  logic [15:0] gap_r;

  logic [2:0]    phase_r;
  logic [23:0]   tick_r;
  logic [CW-1:0] valid_r, left_r;
  logic          unit_r, median_r;
  logic [15:0]   store_r [MAX_SAMPLES];

  logic          echo_r, trig_r, done_r, inval_r, ok_r, med_done_r, need_ins_r;
  logic [15:0]   dist_r;
  logic [24:0]   width_r;   // dividend shift register / quotient
  logic [8:0]    rem_r;
  logic [7:0]    dvs_r;
  logic [4:0]    dcnt_r;
  logic [15:0]   ins_v_r;
  logic [CW-1:0] ins_j_r;
  urm_pkg::out_beat_t out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= 24'd30000; trig_len_r <= 8'd10; per_cm_r <= 8'd58;
      per_inch_r <= 8'd148;   gap_r <= 16'd10000;
    end else if (cfg_we) begin
      case (cfg_index)
        urm_pkg::REG_TIMEOUT: timeout_r  <= cfg_wdata;
        urm_pkg::REG_TRIGLEN: trig_len_r <= cfg_wdata[7:0];
        urm_pkg::REG_CM:      per_cm_r   <= cfg_wdata[7:0];
        urm_pkg::REG_INCH:    per_inch_r <= cfg_wdata[7:0];
        urm_pkg::REG_GAP:     gap_r      <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // phase step, done in the start cycle
  logic [2:0]    ph_n;
  logic [23:0]   tk_n;
  logic [CW-1:0] left_n, valid_n;
  logic          unit_n, med_n, trig_n, ended, ok_n, mdone_n;
  logic [7:0]    s_cl;
  logic [24:0]   tk_inc;

  always_comb begin
    ph_n = phase_r; tk_n = tick_r; left_n = left_r; valid_n = valid_r;
    unit_n = unit_r; med_n = median_r; trig_n = 1'b0; ended = 1'b0;
    ok_n = 1'b0; mdone_n = 1'b0; s_cl = in_data.sample_count;
    if (s_cl < 8'd3) s_cl = 8'd3;
    if (!s_cl[0]) s_cl = s_cl + 8'd1;
    if (s_cl > 8'(TOP)) s_cl = 8'(TOP);
    if (phase_r == PH_IDLE && (in_data.command == urm_pkg::CMD_SINGLE ||
                               in_data.command == urm_pkg::CMD_MEDIAN)) begin
      unit_n = in_data.unit_select;
      med_n  = (in_data.command == urm_pkg::CMD_MEDIAN);
      left_n = med_n ? CW'(s_cl) : CW'(1);
      valid_n = '0; tk_n = '0; ph_n = PH_TLOW;
    end
    tk_inc = {1'b0, tk_n} + 25'd1;
    case (ph_n)
      PH_TLOW: begin
        tk_n = tk_inc[23:0];
        if (tk_inc >= 25'd2) begin ph_n = PH_THIGH; tk_n = '0; end
      end
      PH_THIGH: begin
        trig_n = 1'b1; tk_n = tk_inc[23:0];
        if (tk_inc >= {17'd0, trig_len_r}) begin ph_n = PH_WAIT; tk_n = '0; end
      end
      PH_WAIT: begin
        if (in_data.echo_level) begin ph_n = PH_MEAS; tk_n = '0; end
        else if (tk_n >= timeout_r) ended = 1'b1;
        else tk_n = tk_inc[23:0];
      end
      PH_MEAS: begin
        if (!in_data.echo_level) begin ended = 1'b1; ok_n = 1'b1; end
        else if (tk_n >= timeout_r) ended = 1'b1;
        else tk_n = tk_inc[23:0];
      end
      PH_GAP: begin
        tk_n = tk_inc[23:0];
        if (tk_inc >= {9'd0, gap_r}) begin
          tk_n = '0;
          if (left_n == '0) begin ph_n = PH_IDLE; mdone_n = 1'b1; end
          else ph_n = PH_TLOW;
        end
      end
      default: ph_n = PH_IDLE;
    endcase
    if (ended) begin
      if (med_n) begin
        if (left_n != '0) left_n = left_n - CW'(1);
        ph_n = PH_GAP;
      end else begin
        left_n = '0; ph_n = PH_IDLE;
      end
    end
  end

  logic [8:0] trial;
  assign trial = {rem_r[7:0], width_r[24]};

  // quotient including the bit of the current step
  logic        q_bit;
  logic [24:0] q_nxt;
  assign q_bit = (trial >= {1'b0, dvs_r});
  assign q_nxt = {width_r[23:0], q_bit};

  // divisor picked at start; zero counts as one
  logic [7:0] dvs_sel;
  assign dvs_sel = unit_n ? per_inch_r : per_cm_r;

  assign sts.need_div = ok_r;
  assign sts.need_ins = need_ins_r;
  assign sts.div_last = (dcnt_r == 5'd24);
  assign sts.ins_last = (ins_j_r == '0) || (store_r[IW'(ins_j_r - CW'(1))] <= ins_v_r);

  logic [15:0] qsat;
  assign qsat = (q_nxt[24:16] != '0) ? 16'hFFFF : q_nxt[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE; tick_r <= '0; valid_r <= '0; left_r <= '0;
      unit_r <= 1'b0; median_r <= 1'b0; ok_r <= 1'b0;
    end else if (cmd.start) begin
      phase_r <= ph_n; tick_r <= (ended ? '0 : tk_n); left_r <= left_n;
      valid_r <= valid_n; unit_r <= unit_n; median_r <= med_n;
      ok_r <= ok_n;
    end else if (cmd.ins_step && sts.ins_last) begin
      valid_r <= valid_r + CW'(1);
    end
    if (cmd.start) begin
      trig_r <= trig_n; med_done_r <= mdone_n;
      done_r <= ended && !med_n; inval_r <= ended && !med_n && !ok_n;
      need_ins_r <= med_n && (valid_n < CW'(MAX_SAMPLES));
      width_r <= {1'b0, tk_n} + 25'd1;
      rem_r <= '0; dcnt_r <= '0;
      dvs_r <= (dvs_sel == 8'd0) ? 8'd1 : dvs_sel;
    end
    if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 5'd1;
      if (q_bit) rem_r <= trial - {1'b0, dvs_r};
      else       rem_r <= trial;
      width_r <= q_nxt;
      if (sts.div_last) begin
        ins_j_r <= valid_r; ins_v_r <= qsat;
        if (!median_r) dist_r <= qsat;
      end
    end
    if (cmd.ins_step) begin
      if (sts.ins_last) store_r[IW'(ins_j_r)] <= ins_v_r;
      else begin
        store_r[IW'(ins_j_r)] <= store_r[IW'(ins_j_r - CW'(1))];
        ins_j_r <= ins_j_r - CW'(1);
      end
    end
    if (cmd.finish) begin
      out_r.trigger_level <= trig_r;
      out_r.busy_res <= (phase_r != PH_IDLE);
      if (med_done_r) begin
        out_r.done_res <= 1'b1;
        out_r.invalid  <= (valid_r == '0);
        out_r.distance <= (valid_r == '0) ? 16'd0 : store_r[IW'(valid_r >> 1)];
      end else begin
        out_r.done_res <= done_r;
        out_r.invalid  <= inval_r;
        out_r.distance <= (done_r && !inval_r) ? dist_r : 16'd0;
      end
    end
  end

  assign out_data = out_r;
endmodule

// ----- rtl/core/ultrasonic_range_median.sv -----
// Channel | Beat type            | Handshake
// in_     | urm_pkg::in_beat_t   | in_valid / in_ready, one tick per beat
// out_    | urm_pkg::out_beat_t  | out_valid / out_ready, one result per tick
// cfg_    | 24-bit write data    | cfg_we, index 0..4, no wait
// A tick beat passes through evaluation, finish and output; when a pulse ends
// it also runs the 25-step restoring divider and, in median mode, up to
// MAX_SAMPLES insertion steps, and the result then waits for out_ready.
// Synchronous active-low reset restores register defaults and the idle phase.
// in_ready stays low from acceptance until the result beat is taken.
module ultrasonic_range_median #(
  parameter int MAX_SAMPLES = 9
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  urm_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output urm_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_wdata
);
  urm_pkg::urm_cmd_t cmd;
  urm_pkg::urm_sts_t sts;

  // sequencer: accept, divide, insert, present
  urm_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  // ranging phases, divider, sorted sample store
  urm_datapath #(.MAX_SAMPLES(MAX_SAMPLES)) u_dp (
    .clk, .rst_n, .in_data, .cfg_we, .cfg_index, .cfg_wdata, .cmd, .sts, .out_data
  );
endmodule

// ----- rtl/core/urm_checker.sv -----
module urm_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input urm_pkg::out_beat_t out_data
);
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");
  a_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("second beat taken");
  a_inval_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.invalid |-> out_data.distance == 16'd0)
    else $error("invalid with distance");
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.busy_res)
    else $error("done while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped");
endmodule

bind ultrasonic_range_median urm_checker u_chk (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
